// ===== rtl/rtp_pkg.sv =====
// shared types and constants of the rich text style tag parser
`default_nettype none

package rtp_pkg;

    localparam int WIN_DEPTH   = 9;
    localparam int WIN_BITS    = 8 * WIN_DEPTH;
    localparam int FILL_W      = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_RUN_END = 1'b1;

    localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0] CHAR_STAR       = 8'h2A;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

    // tag patterns, first byte in the top bits
    localparam logic [WIN_BITS-1:0] PAT_BR_SLASH   = {"<br/>", 32'h0};
    localparam logic [WIN_BITS-1:0] PAT_BR_SPACE   = {"<br />", 24'h0};
    localparam logic [WIN_BITS-1:0] PAT_BR_PLAIN   = {"<br>", 40'h0};
    localparam logic [WIN_BITS-1:0] PAT_B_ON       = {"<b>", 48'h0};
    localparam logic [WIN_BITS-1:0] PAT_STRONG_ON  = {"<strong>", 8'h0};
    localparam logic [WIN_BITS-1:0] PAT_B_OFF      = {"</b>", 40'h0};
    localparam logic [WIN_BITS-1:0] PAT_STRONG_OFF = "</strong>";
    localparam logic [WIN_BITS-1:0] PAT_I_ON       = {"<i>", 48'h0};
    localparam logic [WIN_BITS-1:0] PAT_EM_ON      = {"<em>", 40'h0};
    localparam logic [WIN_BITS-1:0] PAT_I_OFF      = {"</i>", 40'h0};
    localparam logic [WIN_BITS-1:0] PAT_EM_OFF     = {"</em>", 32'h0};
    localparam logic [WIN_BITS-1:0] PAT_STARS      = {"**", 56'h0};
    localparam logic [WIN_BITS-1:0] PAT_UNDERS     = {"__", 56'h0};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       carries_byte;
        logic       end_of_text;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] char_out;
        logic       bold;
        logic       italic;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/rtp_in_if.sv =====
// input channel of the parser: one text byte per transaction
`default_nettype none

interface rtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       carries_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output carries_byte,
                    output end_of_text, input ready);
    modport sink (input valid, input text_byte, input carries_byte,
                  input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtp_out_if.sv =====
// result channel of the parser: one styled character or run end per transaction
`default_nettype none

interface rtp_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] char_out;
    logic       bold;
    logic       italic;
    logic       last_result;

    modport source (output valid, output result_kind, output char_out, output bold,
                    output italic, output last_result, input ready);
    modport sink (input valid, input result_kind, input char_out, input bold,
                  input italic, input last_result, output ready);
endinterface

`default_nettype wire

// ===== rtl/rtp_front.sv =====
// front end: accepts input transactions, drops idle ones, queues the rest
`default_nettype none

module rtp_front (
    input  logic          clk,
    input  logic          rst_n,
    rtp_in_if.sink        text_in,
    output logic          q_valid,
    input  logic          q_ready,
    output rtp_pkg::item_t q_data
);
    import rtp_pkg::*;

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    logic                accept;
    logic                push;
    logic                pop;
    item_t               in_item;

    assign in_item.text_byte    = text_in.text_byte;
    assign in_item.carries_byte = text_in.carries_byte;
    assign in_item.end_of_text  = text_in.end_of_text;

    assign text_in.ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign accept        = text_in.valid && text_in.ready;
    // an item with neither byte nor end has no effect
    assign push          = accept && (in_item.carries_byte || in_item.end_of_text);
    assign q_valid       = (count_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_data        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rtp_back.sv =====
// back end: lookahead window, tag decision, run tracking and result register
`default_nettype none

module rtp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  rtp_pkg::item_t q_data,
    rtp_out_if.source      result_out
);
    import rtp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DRAIN = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    typedef struct packed {
        logic              has_res;
        result_t           res;
        logic [FILL_W-1:0] drop;
        logic              bold;
        logic              italic;
        logic              run;
    } decision_t;

    function automatic logic has_pat(input logic [WIN_BITS-1:0] w,
                                     input logic [FILL_W-1:0] f,
                                     input logic [WIN_BITS-1:0] pat,
                                     input logic [FILL_W-1:0] len);
        logic ok;
        ok = (len <= f);
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            if ((FILL_W'(i) < len) && (w[8*i +: 8] != pat[WIN_BITS-1-8*i -: 8]))
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic decision_t decide(input logic [WIN_BITS-1:0] w,
                                         input logic [FILL_W-1:0] f,
                                         input logic b,
                                         input logic it,
                                         input logic run);
        decision_t d;
        result_t   run_end;
        logic      close;
        run_end   = '{result_kind: KIND_RUN_END, char_out: 8'h00, bold: b, italic: it};
        close     = 1'b0;
        d.has_res = 1'b1;
        d.res     = '{result_kind: KIND_CHAR, char_out: w[7:0], bold: b, italic: it};
        d.drop    = FILL_W'(1);
        d.bold    = b;
        d.italic  = it;
        d.run     = 1'b1;
        priority if (has_pat(w, f, PAT_BR_SLASH, 4'd5))
        begin
            d.res.char_out = CHAR_NEWLINE;
            d.drop         = 4'd5;
        end
        else if (has_pat(w, f, PAT_BR_SPACE, 4'd6))
        begin
            d.res.char_out = CHAR_NEWLINE;
            d.drop         = 4'd6;
        end
        else if (has_pat(w, f, PAT_BR_PLAIN, 4'd4))
        begin
            d.res.char_out = CHAR_NEWLINE;
            d.drop         = 4'd4;
        end
        else if (has_pat(w, f, PAT_B_ON, 4'd3) || has_pat(w, f, PAT_STRONG_ON, 4'd8))
        begin
            close  = 1'b1;
            d.bold = 1'b1;
            d.drop = has_pat(w, f, PAT_B_ON, 4'd3) ? 4'd3 : 4'd8;
        end
        else if (has_pat(w, f, PAT_B_OFF, 4'd4) || has_pat(w, f, PAT_STRONG_OFF, 4'd9))
        begin
            close  = 1'b1;
            d.bold = 1'b0;
            d.drop = has_pat(w, f, PAT_B_OFF, 4'd4) ? 4'd4 : 4'd9;
        end
        else if (has_pat(w, f, PAT_I_ON, 4'd3) || has_pat(w, f, PAT_EM_ON, 4'd4))
        begin
            close    = 1'b1;
            d.italic = 1'b1;
            d.drop   = has_pat(w, f, PAT_I_ON, 4'd3) ? 4'd3 : 4'd4;
        end
        else if (has_pat(w, f, PAT_I_OFF, 4'd4) || has_pat(w, f, PAT_EM_OFF, 4'd5))
        begin
            close    = 1'b1;
            d.italic = 1'b0;
            d.drop   = has_pat(w, f, PAT_I_OFF, 4'd4) ? 4'd4 : 4'd5;
        end
        else if (has_pat(w, f, PAT_STARS, 4'd2) || has_pat(w, f, PAT_UNDERS, 4'd2))
        begin
            close  = 1'b1;
            d.bold = ~b;
            d.drop = 4'd2;
        end
        else if ((w[7:0] == CHAR_STAR) || (w[7:0] == CHAR_UNDERSCORE))
        begin
            close    = 1'b1;
            d.italic = ~it;
        end
        else
        begin
            d.has_res = 1'b1;
        end
        if (close)
        begin
            d.has_res = run;
            d.res     = run_end;
            d.run     = 1'b0;
        end
        return d;
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [WIN_BITS-1:0] window_reg, window_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                bold_reg, bold_next;
    logic                italic_reg, italic_next;
    logic                run_reg, run_next;
    logic                pend_valid_reg, pend_valid_next;
    result_t             pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;
    logic                out_last_reg, out_last_next;

    logic                out_load_ok;
    logic [WIN_BITS-1:0] w_app;
    logic [FILL_W-1:0]   f_app;
    logic [WIN_BITS-1:0] base_w;
    logic [FILL_W-1:0]   base_f;
    decision_t           dec;
    logic                res_valid;
    result_t             res_data;

    assign out_load_ok = !out_valid_reg || result_out.ready;

    // window with the queued byte appended
    always_comb
    begin
        w_app = window_reg;
        f_app = fill_reg;
        if (q_data.carries_byte && (fill_reg < FILL_W'(WIN_DEPTH)))
        begin
            w_app[{fill_reg, 3'b000} +: 8] = q_data.text_byte;
            f_app                          = fill_reg + 1'b1;
        end
    end

    assign base_w = (state_reg == S_IDLE) ? w_app : window_reg;
    assign base_f = (state_reg == S_IDLE) ? f_app : fill_reg;
    assign dec    = decide(base_w, base_f, bold_reg, italic_reg, run_reg);

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        fill_next       = fill_reg;
        bold_next       = bold_reg;
        italic_next     = italic_reg;
        run_next        = run_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        q_ready         = 1'b0;
        res_valid       = 1'b0;
        res_data        = dec.res;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_load_ok)
                begin
                    q_ready     = 1'b1;
                    window_next = w_app;
                    fill_next   = f_app;
                    if (f_app == FILL_W'(WIN_DEPTH))
                    begin
                        window_next = w_app >> {dec.drop, 3'b000};
                        fill_next   = f_app - dec.drop;
                        bold_next   = dec.bold;
                        italic_next = dec.italic;
                        run_next    = dec.run;
                        res_valid   = dec.has_res;
                    end
                    if (q_data.end_of_text)
                    begin
                        state_next = S_DRAIN;
                        if (res_valid)
                        begin
                            pend_valid_next = 1'b1;
                            pend_next       = res_data;
                        end
                    end
                    else if (res_valid)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = res_data;
                        out_last_next  = 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (out_load_ok)
                begin
                    if (fill_reg != '0)
                    begin
                        window_next = window_reg >> {dec.drop, 3'b000};
                        fill_next   = fill_reg - dec.drop;
                        bold_next   = dec.bold;
                        italic_next = dec.italic;
                        run_next    = dec.run;
                        res_valid   = dec.has_res;
                    end
                    else
                    begin
                        // close the last run and return to regular style
                        res_valid   = run_reg;
                        res_data    = '{result_kind: KIND_RUN_END, char_out: 8'h00,
                                        bold: bold_reg, italic: italic_reg};
                        bold_next   = 1'b0;
                        italic_next = 1'b0;
                        run_next    = 1'b0;
                        state_next  = S_FLUSH;
                    end
                    if (res_valid)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_next       = res_data;
                    end
                end
            end
            S_FLUSH:
            begin
                if (out_load_ok)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = pend_reg;
                        out_last_next  = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            bold_reg       <= 1'b0;
            italic_reg     <= 1'b0;
            run_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bold_reg       <= bold_next;
            italic_reg     <= italic_next;
            run_reg        <= run_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        window_reg   <= window_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.result_kind = out_reg.result_kind;
    assign result_out.char_out    = out_reg.char_out;
    assign result_out.bold        = out_reg.bold;
    assign result_out.italic      = out_reg.italic;
    assign result_out.last_result = out_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WIN_DEPTH))
        else $error("window fill beyond depth");

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_valid_reg)
        else $error("held result left over between texts");

    a_mid_text_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && q_valid && q_ready && !q_data.end_of_text
        |=> fill_reg < FILL_W'(WIN_DEPTH))
        else $error("window still full after a mid-text item");

    a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH) && out_load_ok |=> (state_reg == S_IDLE) && !bold_reg
        && !italic_reg && !run_reg && (fill_reg == '0))
        else $error("drain did not leave a clean state");
`endif

endmodule

`default_nettype wire

// ===== rtl/rich_text_style_tag_parser_top.sv =====
// top level of the rich text style tag parser
//
// text_in takes one text byte per transaction with carries_byte and end_of_text
// flags; result_out gives styled characters and run-end markers, last_result
// set on the final result caused by an input transaction.
// mid-text a transaction is taken every cycle while result_out does not stall
// and gives at most one result, registered, in the cycle after it leaves the
// two-entry input queue. an end_of_text transaction drains the nine-byte window:
// one head decision a cycle in the back end while result_out does not stall,
// then run close and final result; the next text waits in the input queue.
// transactions with neither a byte nor end_of_text are taken and dropped.
// reset clears the queue, the window fill, style and run state; window bytes
// are not cleared.
// when result_out stalls, the held result stays put, the back end stops and
// the input queue fills, after which text_in.ready drops.
`default_nettype none

module rich_text_style_tag_parser_top (
    input  logic      clk,
    input  logic      rst_n,
    rtp_in_if.sink    text_in,
    rtp_out_if.source result_out
);
    import rtp_pkg::*;

    logic  q_valid;
    logic  q_ready;
    item_t q_data;

    rtp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    rtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .result_out (result_out)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench of the rich text style tag parser: random and directed text, predicted styled output
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rtp_pkg::*;

    typedef struct packed {
        result_t res;
        logic    last;
    } styled_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    rtp_in_if  text_in ();
    rtp_out_if result_out ();

    rich_text_style_tag_parser_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .result_out (result_out)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    item_t          pending_items[$];
    logic [7:0]     text_q[$];
    styled_result_t styled_expected[$];
    styled_result_t item_batch[$];

    int unsigned text_items_queued = 0;
    int unsigned items_taken = 0;
    int unsigned mismatches = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          calm;

    // own copy of the parser state
    logic [7:0]  look_win [0:WIN_DEPTH-1];
    int unsigned look_fill = 0;
    logic        bold_now = 1'b0;
    logic        italic_now = 1'b0;
    logic        run_open = 1'b0;

    assign calm = (items_taken >= 90) && (items_taken < 140);

    function automatic bit window_starts(string pat);
        int unsigned i;
        if (pat.len() > look_fill)
            return 1'b0;
        for (i = 0; i < pat.len(); i++)
        begin
            if (look_win[i] != pat[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_styled(logic kind, logic [7:0] ch);
        styled_result_t e;
        e.res.result_kind = kind;
        e.res.char_out    = ch;
        e.res.bold        = bold_now;
        e.res.italic      = italic_now;
        e.last            = 1'b0;
        item_batch.push_back(e);
    endtask

    task automatic drop_head(int unsigned k);
        int unsigned i;
        if (k > look_fill)
            k = look_fill;
        for (i = 0; i + k < look_fill; i++)
            look_win[i] = look_win[i + k];
        look_fill = look_fill - k;
    endtask

    task automatic end_run();
        if (run_open)
        begin
            add_styled(KIND_RUN_END, 8'h00);
            run_open = 1'b0;
        end
    endtask

    task automatic decide_window_head();
        logic [7:0] c;
        if (window_starts("<br/>"))
        begin
            add_styled(KIND_CHAR, CHAR_NEWLINE);
            run_open = 1'b1;
            drop_head(5);
        end
        else if (window_starts("<br />"))
        begin
            add_styled(KIND_CHAR, CHAR_NEWLINE);
            run_open = 1'b1;
            drop_head(6);
        end
        else if (window_starts("<br>"))
        begin
            add_styled(KIND_CHAR, CHAR_NEWLINE);
            run_open = 1'b1;
            drop_head(4);
        end
        else if (window_starts("<b>") || window_starts("<strong>"))
        begin
            end_run();
            bold_now = 1'b1;
            drop_head(window_starts("<b>") ? 3 : 8);
        end
        else if (window_starts("</b>") || window_starts("</strong>"))
        begin
            end_run();
            bold_now = 1'b0;
            drop_head(window_starts("</b>") ? 4 : 9);
        end
        else if (window_starts("<i>") || window_starts("<em>"))
        begin
            end_run();
            italic_now = 1'b1;
            drop_head(window_starts("<i>") ? 3 : 4);
        end
        else if (window_starts("</i>") || window_starts("</em>"))
        begin
            end_run();
            italic_now = 1'b0;
            drop_head(window_starts("</i>") ? 4 : 5);
        end
        else if (window_starts("**") || window_starts("__"))
        begin
            end_run();
            bold_now = ~bold_now;
            drop_head(2);
        end
        else if (look_fill > 0)
        begin
            c = look_win[0];
            if (c == CHAR_STAR || c == CHAR_UNDERSCORE)
            begin
                end_run();
                italic_now = ~italic_now;
            end
            else
            begin
                add_styled(KIND_CHAR, c);
                run_open = 1'b1;
            end
            drop_head(1);
        end
    endtask

    task automatic predict_styled(item_t it);
        styled_result_t e;
        int unsigned    i;
        if (it.carries_byte && look_fill < WIN_DEPTH)
        begin
            look_win[look_fill] = it.text_byte;
            look_fill++;
        end
        while (look_fill >= WIN_DEPTH)
            decide_window_head();
        if (it.end_of_text)
        begin
            while (look_fill > 0)
                decide_window_head();
            end_run();
            bold_now   = 1'b0;
            italic_now = 1'b0;
        end
        for (i = 0; i < item_batch.size(); i++)
        begin
            e      = item_batch[i];
            e.last = (i == item_batch.size() - 1);
            styled_expected.push_back(e);
        end
        item_batch.delete();
    endtask

    function automatic item_t make_item(logic [7:0] b, logic carries, logic eot);
        item_t it;
        it.text_byte    = b;
        it.carries_byte = carries;
        it.end_of_text  = eot;
        return it;
    endfunction

    function automatic string markup_token(int unsigned k);
        case (k)
            0:       return "<br/>";
            1:       return "<br />";
            2:       return "<br>";
            3:       return "<b>";
            4:       return "<strong>";
            5:       return "</b>";
            6:       return "</strong>";
            7:       return "<i>";
            8:       return "<em>";
            9:       return "</i>";
            10:      return "</em>";
            11:      return "**";
            12:      return "__";
            13:      return "*";
            default: return "_";
        endcase
    endfunction

    task automatic append_token(string s, int unsigned len);
        int unsigned i;
        for (i = 0; i < len && i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic queue_idle();
        pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
    endtask

    // end_apart: close with a byteless transaction instead of flagging the last byte
    task automatic queue_text(bit end_apart, int unsigned idle_pct);
        int unsigned i;
        for (i = 0; i < text_q.size(); i++)
        begin
            if ($urandom_range(0, 99) < idle_pct)
                queue_idle();
            pending_items.push_back(make_item(text_q[i], 1'b1,
                                              !end_apart && (i == text_q.size() - 1)));
            text_items_queued++;
        end
        if (end_apart)
        begin
            pending_items.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
            text_items_queued++;
        end
        text_q.delete();
    endtask

    task automatic build_random_text();
        int unsigned n_tokens;
        int unsigned r;
        int unsigned t;
        string       s;
        n_tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 6);
        for (t = 0; t < n_tokens; t++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                s = markup_token($urandom_range(0, 14));
                append_token(s, s.len());
            end
            else if (r < 80)
            begin
                repeat ($urandom_range(1, 4))
                    text_q.push_back(($urandom_range(0, 3) == 0) ? 8'h20
                                     : 8'($urandom_range(97, 122)));
            end
            else if (r < 90)
            begin
                // broken tag
                s = markup_token($urandom_range(0, 10));
                append_token(s, $urandom_range(1, s.len() - 1));
            end
            else
            begin
                text_q.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_in.valid        <= 1'b0;
            text_in.text_byte    <= 8'h00;
            text_in.carries_byte <= 1'b0;
            text_in.end_of_text  <= 1'b0;
        end
        else
        begin
            if (text_in.valid && text_in.ready)
            begin
                predict_styled(make_item(text_in.text_byte, text_in.carries_byte,
                                         text_in.end_of_text));
                items_taken <= items_taken + 1;
            end
            if (!text_in.valid || text_in.ready)
            begin
                if (pending_items.size() > 0 &&
                    (calm || hold_left > 0 || $urandom_range(0, 99) >= 16))
                begin
                    text_in.valid        <= 1'b1;
                    text_in.text_byte    <= pending_items[0].text_byte;
                    text_in.carries_byte <= pending_items[0].carries_byte;
                    text_in.end_of_text  <= pending_items[0].end_of_text;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    text_in.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_taken >= 50)
        begin
            hold_left <= 80;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        styled_result_t want;
        if (!rst_n)
        begin
            result_out.ready <= 1'b0;
        end
        else
        begin
            if (result_out.valid && result_out.ready)
            begin
                if (styled_expected.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result: kind %0b char %02h bold %0b italic %0b last %0b",
                                 result_out.result_kind, result_out.char_out, result_out.bold,
                                 result_out.italic, result_out.last_result);
                    mismatches++;
                end
                else
                begin
                    want = styled_expected.pop_front();
                    if (result_out.result_kind !== want.res.result_kind ||
                        result_out.char_out !== want.res.char_out ||
                        result_out.bold !== want.res.bold ||
                        result_out.italic !== want.res.italic ||
                        result_out.last_result !== want.last)
                    begin
                        if (mismatches < 10)
                            $display({"mismatch: expected kind %0b char %02h bold %0b italic %0b",
                                      " last %0b, got kind %0b char %02h bold %0b italic %0b",
                                      " last %0b"},
                                     want.res.result_kind, want.res.char_out, want.res.bold,
                                     want.res.italic, want.last, result_out.result_kind,
                                     result_out.char_out, result_out.bold, result_out.italic,
                                     result_out.last_result);
                        mismatches++;
                    end
                end
            end
            result_out.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 16);
        end
    end

    initial
    begin
        rst_n <= 1'b0;

        // idle transaction and a text with no bytes at all
        queue_idle();
        pending_items.push_back(make_item(8'hA5, 1'b0, 1'b1));
        // zero byte and the byte extremes
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(8'h01);
        queue_text(1'b0, 0);
        // style toggle only: empty run at end
        append_token("__", 2);
        queue_text(1'b1, 0);
        // tag cut by the end of text
        append_token("<stro", 5);
        queue_text(1'b0, 0);
        // full window drained at once
        append_token("abcdefghi", 9);
        queue_text(1'b0, 0);

        while (text_items_queued < 170)
        begin
            build_random_text();
            queue_text($urandom_range(0, 3) == 0, 5);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || text_in.valid)
            @(posedge clk);
        while (styled_expected.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== rich_text_style_tag_parser_top.f =====
rtl/rtp_pkg.sv
rtl/rtp_in_if.sv
rtl/rtp_out_if.sv
rtl/rtp_front.sv
rtl/rtp_back.sv
rtl/rich_text_style_tag_parser_top.sv
bench/tb.sv
